### hdl/arprr_pkg.sv
// shared types, constants and reply byte table for the arp request responder
package arprr_pkg;

  localparam int ReplyLengthDefault = 60;
  localparam int PosWidth           = 6;
  localparam logic [PosWidth-1:0] PosMax = '1;
  localparam int HdrBytes           = 22;
  localparam int AddrBytes          = 42;

  // configuration register indexes
  localparam logic CfgOwnIpv4 = 1'b0;
  localparam logic CfgOwnMac  = 1'b1;

  localparam logic [15:0] EtherTypeArp = 16'h0806;
  localparam logic [15:0] HwTypeEth    = 16'h0001;
  localparam logic [15:0] ProtoIpv4    = 16'h0800;
  localparam logic [7:0]  HwAddrLen    = 8'd6;
  localparam logic [7:0]  ProtoAddrLen = 8'd4;
  localparam logic [15:0] OpRequest    = 16'h0001;
  localparam logic [15:0] OpReply      = 16'h0002;

  typedef enum logic [2:0] {
    VerdictReply      = 3'd0,
    VerdictShort      = 3'd1,
    VerdictFormat     = 3'd2,
    VerdictNotRequest = 3'd3,
    VerdictNotOurs    = 3'd4
  } verdict_t;

  typedef struct packed {
    verdict_t    verdict;
    logic [47:0] sender_mac;
    logic [31:0] sender_ipv4;
  } job_t;

  function automatic logic [7:0] reply_byte(
    input logic [PosWidth-1:0] idx,
    input logic [47:0]         peer_mac,
    input logic [31:0]         peer_ipv4,
    input logic [47:0]         own_mac,
    input logic [31:0]         own_ipv4
  );
    logic [8*AddrBytes-1:0] frame;
    logic [PosWidth-1:0]    k;
    logic [7:0]             res;
    frame = {peer_mac, own_mac, EtherTypeArp, HwTypeEth, ProtoIpv4, HwAddrLen,
             ProtoAddrLen, OpReply, own_mac, own_ipv4, peer_mac, peer_ipv4};
    k = PosWidth'(AddrBytes - 1) - idx;
    if (idx < PosWidth'(AddrBytes)) begin
      res = frame[{k, 3'b000} +: 8];
    end else begin
      res = 8'h00;
    end
    return res;
  endfunction

endpackage

### hdl/arp_request_responder_core.sv
// arp request responder: frame byte intake, request checks and reply burst
// Takes one frame byte per cycle. A frame's last byte produces either one reject beat
// or a ReplyLength-beat reply (default 60) streamed at one beat per cycle from the output
// register while out_ready is high. Bytes of the next frame keep flowing during a reply
// burst; only that frame's last byte is held until the reply sequencer has handed out the
// final beat of the previous burst, so back-to-back frames of at least ReplyLength bytes
// never stall while out_ready is high. own_ipv4 and own_mac must be written by the user
// through the cfg port only while no frame is in flight; the block does not enforce this.
module arp_request_responder_core #(
  parameter int ReplyLength = arprr_pkg::ReplyLengthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic [2:0]  verdict,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [47:0] cfg_data
);

  logic [31:0]      own_ipv4;
  logic [47:0]      own_mac;
  logic             job_valid;
  logic             load_ready;
  arprr_pkg::job_t  job;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_ipv4 <= '0;
      own_mac  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        arprr_pkg::CfgOwnIpv4: own_ipv4 <= cfg_data[31:0];
        arprr_pkg::CfgOwnMac:  own_mac  <= cfg_data;
        default: ;
      endcase
    end
  end

  arprr_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .in_last    (in_last),
    .own_ipv4   (own_ipv4),
    .load_ready (load_ready),
    .job_valid  (job_valid),
    .job        (job)
  );

  arprr_emit #(
    .ReplyLength (ReplyLength)
  ) u_emit (
    .clk        (clk),
    .rst        (rst),
    .job_valid  (job_valid),
    .job        (job),
    .load_ready (load_ready),
    .own_mac    (own_mac),
    .own_ipv4   (own_ipv4),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .out_last   (out_last),
    .verdict    (verdict)
  );

endmodule

### hdl/arprr_parse.sv
// input register, header capture and request checks
module arprr_parse (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  input  logic [31:0]         own_ipv4,
  input  logic                load_ready,
  output logic                job_valid,
  output arprr_pkg::job_t     job
);

  logic                                q_valid;
  logic [7:0]                          q_byte;
  logic                                q_last;
  logic [arprr_pkg::PosWidth-1:0]      pos;
  logic [15:0]                         hw_kind, hw_kind_next;
  logic [15:0]                         proto_kind, proto_kind_next;
  logic [7:0]                          hw_len, hw_len_next;
  logic [7:0]                          proto_len, proto_len_next;
  logic [15:0]                         arp_op, arp_op_next;
  logic [47:0]                         sender_mac, sender_mac_next;
  logic [31:0]                         sender_ipv4, sender_ipv4_next;
  logic [31:0]                         target_ipv4, target_ipv4_next;
  logic                                fire;
  arprr_pkg::verdict_t                 verdict;

  assign fire      = q_valid && (!q_last || load_ready);
  assign in_ready  = !q_valid || fire;
  assign job_valid = q_valid && q_last;

  // field capture for the beat in the input register
  always_comb begin
    hw_kind_next     = hw_kind;
    proto_kind_next  = proto_kind;
    hw_len_next      = hw_len;
    proto_len_next   = proto_len;
    arp_op_next      = arp_op;
    sender_mac_next  = sender_mac;
    sender_ipv4_next = sender_ipv4;
    target_ipv4_next = target_ipv4;
    unique case (pos) inside
      [6'd14:6'd15]: hw_kind_next     = {hw_kind[7:0], q_byte};
      [6'd16:6'd17]: proto_kind_next  = {proto_kind[7:0], q_byte};
      6'd18:         hw_len_next      = q_byte;
      6'd19:         proto_len_next   = q_byte;
      [6'd20:6'd21]: arp_op_next      = {arp_op[7:0], q_byte};
      [6'd22:6'd27]: sender_mac_next  = {sender_mac[39:0], q_byte};
      [6'd28:6'd31]: sender_ipv4_next = {sender_ipv4[23:0], q_byte};
      [6'd38:6'd41]: target_ipv4_next = {target_ipv4[23:0], q_byte};
      default: ;
    endcase
  end

  always_comb begin
    if (pos < arprr_pkg::PosWidth'(arprr_pkg::HdrBytes - 1)) begin
      verdict = arprr_pkg::VerdictShort;
    end else if (hw_kind_next != arprr_pkg::HwTypeEth ||
                 proto_kind_next != arprr_pkg::ProtoIpv4 ||
                 hw_len_next != arprr_pkg::HwAddrLen ||
                 proto_len_next != arprr_pkg::ProtoAddrLen) begin
      verdict = arprr_pkg::VerdictFormat;
    end else if (pos < arprr_pkg::PosWidth'(arprr_pkg::AddrBytes - 1)) begin
      verdict = arprr_pkg::VerdictShort;
    end else if (arp_op_next != arprr_pkg::OpRequest) begin
      verdict = arprr_pkg::VerdictNotRequest;
    end else if (target_ipv4_next != own_ipv4) begin
      verdict = arprr_pkg::VerdictNotOurs;
    end else begin
      verdict = arprr_pkg::VerdictReply;
    end
  end

  assign job.verdict     = verdict;
  assign job.sender_mac  = sender_mac_next;
  assign job.sender_ipv4 = sender_ipv4_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid     <= 1'b0;
      pos         <= '0;
      hw_kind     <= '0;
      proto_kind  <= '0;
      hw_len      <= '0;
      proto_len   <= '0;
      arp_op      <= '0;
      sender_mac  <= '0;
      sender_ipv4 <= '0;
      target_ipv4 <= '0;
    end else begin
      if (in_ready) begin
        q_valid <= in_valid;
      end
      if (fire) begin
        hw_kind     <= hw_kind_next;
        proto_kind  <= proto_kind_next;
        hw_len      <= hw_len_next;
        proto_len   <= proto_len_next;
        arp_op      <= arp_op_next;
        sender_mac  <= sender_mac_next;
        sender_ipv4 <= sender_ipv4_next;
        target_ipv4 <= target_ipv4_next;
        if (q_last) begin
          pos <= '0;
        end else if (pos != arprr_pkg::PosMax) begin
          pos <= pos + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      q_byte <= in_byte;
      q_last <= in_last;
    end
  end

endmodule

### hdl/arprr_emit.sv
// reply sequencer driving the output register
module arprr_emit #(
  parameter int ReplyLength = arprr_pkg::ReplyLengthDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                job_valid,
  input  arprr_pkg::job_t     job,
  output logic                load_ready,
  input  logic [47:0]         own_mac,
  input  logic [31:0]         own_ipv4,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic                out_last,
  output logic [2:0]          verdict
);

  localparam logic [arprr_pkg::PosWidth-1:0] LastIdx =
    arprr_pkg::PosWidth'(ReplyLength - 1);

  logic [arprr_pkg::PosWidth-1:0] idx, idx_next;
  logic [47:0]                    peer_mac;
  logic [31:0]                    peer_ipv4;
  arprr_pkg::verdict_t            out_verdict;
  logic                           load;
  logic                           step;

  assign load_ready = !out_valid || (out_ready && out_last);
  assign load       = job_valid && load_ready;
  assign step       = out_valid && out_ready && !out_last;
  assign idx_next   = idx + 1'b1;
  assign verdict    = out_verdict;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_valid && out_ready && out_last) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      idx         <= '0;
      peer_mac    <= job.sender_mac;
      peer_ipv4   <= job.sender_ipv4;
      out_verdict <= job.verdict;
      if (job.verdict == arprr_pkg::VerdictReply) begin
        out_byte <= arprr_pkg::reply_byte('0, job.sender_mac, job.sender_ipv4,
                                          own_mac, own_ipv4);
        out_last <= (LastIdx == '0);
      end else begin
        out_byte <= 8'h00;
        out_last <= 1'b1;
      end
    end else if (step) begin
      idx      <= idx_next;
      out_byte <= arprr_pkg::reply_byte(idx_next, peer_mac, peer_ipv4, own_mac, own_ipv4);
      out_last <= (idx_next == LastIdx);
    end
  end

endmodule

### hdl/arprr_checker.sv
// port-level assertions for the arp request responder, bound to the top level
module arprr_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic        out_last,
  input logic [2:0]  verdict
);

  // no beat right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output beat right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last) &&
    $stable(verdict))
    else $error("stalled output beat changed");

  // a reject is a single zero beat
  a_reject_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && verdict != arprr_pkg::VerdictReply |-> out_last && out_byte == 8'h00)
    else $error("reject beat not single zero beat");

  // reply burst runs without gaps
  a_burst_gapless: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_last |=> out_valid && verdict == arprr_pkg::VerdictReply)
    else $error("gap or verdict change inside reply burst");

endmodule

bind arp_request_responder_core arprr_checker u_arprr_checker (.*);

### sim/testbench.sv
// self-checking testbench for the arp request responder core
`timescale 1ns / 1ps

module testbench;

  typedef struct {
    logic [7:0]          data;
    logic                last;
    arprr_pkg::verdict_t verdict;
  } reply_beat_t;

  typedef struct {
    logic [7:0]          data;
    logic                last;
    int                  gap;
    bit                  fixed;
    arprr_pkg::verdict_t fixed_verdict;
  } frame_beat_t;

  typedef struct {
    int                  len;
    logic [15:0]         htype;
    logic [15:0]         ptype;
    logic [7:0]          hlen;
    logic [7:0]          plen;
    logic [15:0]         op;
    bit                  ours;
    logic [7:0]          fill;
    bit                  fixed;
    arprr_pkg::verdict_t fixed_verdict;
  } directed_frame_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = 8'h00;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        out_last;
  logic [2:0]  verdict;
  logic        cfg_write = 1'b0;
  logic        cfg_index = 1'b0;
  logic [47:0] cfg_data = '0;

  // predictor copy of the block
  logic [31:0] our_ipv4;
  logic [47:0] our_mac;
  logic [5:0]  rx_pos;
  logic [15:0] seen_hw_type;
  logic [15:0] seen_proto;
  logic [7:0]  seen_hlen;
  logic [7:0]  seen_plen;
  logic [15:0] seen_op;
  logic [47:0] seen_peer_mac;
  logic [31:0] seen_peer_ipv4;
  logic [31:0] seen_target_ipv4;

  reply_beat_t     reply_beats[$];
  frame_beat_t     frame_beats[$];
  frame_beat_t     cur_beat;
  directed_frame_t directed_frames[4];
  reply_beat_t     want;
  int              wait_cnt = 0;
  int              stall_left = 0;
  int              stall_draw;
  int              errors = 0;
  int              queued = 0;
  bit              hold_req = 1'b0;
  logic            hold_off = 1'b0;

  arp_request_responder_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .verdict   (verdict),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic arp_absorb_byte(input logic [7:0] b, input logic last, input bit push);
    logic [5:0]          p;
    int                  flen;
    int                  cnt;
    arprr_pkg::verdict_t v;
    logic [7:0]          img[64];
    reply_beat_t         rb;
    p = rx_pos;
    if (p == 14 || p == 15) seen_hw_type = {seen_hw_type[7:0], b};
    else if (p == 16 || p == 17) seen_proto = {seen_proto[7:0], b};
    else if (p == 18) seen_hlen = b;
    else if (p == 19) seen_plen = b;
    else if (p == 20 || p == 21) seen_op = {seen_op[7:0], b};
    else if (p >= 22 && p <= 27) seen_peer_mac = {seen_peer_mac[39:0], b};
    else if (p >= 28 && p <= 31) seen_peer_ipv4 = {seen_peer_ipv4[23:0], b};
    else if (p >= 38 && p <= 41) seen_target_ipv4 = {seen_target_ipv4[23:0], b};
    if (!last) begin
      if (p != arprr_pkg::PosMax) rx_pos = p + 6'd1;
    end else begin
      flen = int'(p) + 1;
      rx_pos = '0;
      if (flen < arprr_pkg::HdrBytes) v = arprr_pkg::VerdictShort;
      else if (seen_hw_type != arprr_pkg::HwTypeEth || seen_proto != arprr_pkg::ProtoIpv4 ||
               seen_hlen != arprr_pkg::HwAddrLen || seen_plen != arprr_pkg::ProtoAddrLen)
        v = arprr_pkg::VerdictFormat;
      else if (flen < arprr_pkg::AddrBytes) v = arprr_pkg::VerdictShort;
      else if (seen_op != arprr_pkg::OpRequest) v = arprr_pkg::VerdictNotRequest;
      else if (seen_target_ipv4 != our_ipv4) v = arprr_pkg::VerdictNotOurs;
      else v = arprr_pkg::VerdictReply;
      if (push && v != arprr_pkg::VerdictReply) begin
        rb = '{8'h00, 1'b1, v};
        reply_beats.push_back(rb);
      end else if (push) begin
        for (int i = 0; i < 64; i++) img[i] = 8'h00;
        for (int i = 0; i < 6; i++) begin
          img[i]      = seen_peer_mac[8*(5-i) +: 8];
          img[6 + i]  = our_mac[8*(5-i) +: 8];
          img[22 + i] = our_mac[8*(5-i) +: 8];
          img[32 + i] = seen_peer_mac[8*(5-i) +: 8];
        end
        for (int i = 0; i < 4; i++) begin
          img[28 + i] = our_ipv4[8*(3-i) +: 8];
          img[38 + i] = seen_peer_ipv4[8*(3-i) +: 8];
        end
        img[12] = 8'h08; img[13] = 8'h06;
        img[14] = 8'h00; img[15] = 8'h01;
        img[16] = 8'h08; img[17] = 8'h00;
        img[18] = 8'h06; img[19] = 8'h04;
        img[20] = 8'h00; img[21] = 8'h02;
        cnt = arprr_pkg::ReplyLengthDefault;
        if (cnt > 64) cnt = 64;
        if (cnt < 1) cnt = 1;
        for (int i = 0; i < cnt; i++) begin
          rb = '{img[i], logic'(i == cnt - 1), arprr_pkg::VerdictReply};
          reply_beats.push_back(rb);
        end
      end
    end
  endtask

  task automatic queue_frame(input int len, input logic [15:0] htype, input logic [15:0] ptype,
                             input logic [7:0] hlen, input logic [7:0] plen,
                             input logic [15:0] op, input logic [31:0] tip,
                             input logic [47:0] smac, input logic [31:0] sip,
                             input logic [7:0] fill, input bit use_rand, input bit fixed,
                             input arprr_pkg::verdict_t fv);
    frame_beat_t fb;
    logic [7:0]  d;
    logic [15:0] etype;
    etype = (use_rand && $urandom_range(0, 7) == 0) ? 16'($urandom) : arprr_pkg::EtherTypeArp;
    for (int p = 0; p < len; p++) begin
      if (p == 12 || p == 13) d = etype[8*(13-p) +: 8];
      else if (p == 14 || p == 15) d = htype[8*(15-p) +: 8];
      else if (p == 16 || p == 17) d = ptype[8*(17-p) +: 8];
      else if (p == 18) d = hlen;
      else if (p == 19) d = plen;
      else if (p == 20 || p == 21) d = op[8*(21-p) +: 8];
      else if (p >= 22 && p <= 27) d = smac[8*(27-p) +: 8];
      else if (p >= 28 && p <= 31) d = sip[8*(31-p) +: 8];
      else if (p >= 38 && p <= 41) d = tip[8*(41-p) +: 8];
      else if (use_rand) d = 8'($urandom_range(0, 255));
      else d = fill;
      fb.data = d;
      fb.last = (p == len - 1);
      fb.gap = $urandom_range(0, 12);
      fb.fixed = fixed && (p == len - 1);
      fb.fixed_verdict = fv;
      frame_beats.push_back(fb);
    end
    queued = queued + len;
  endtask

  task automatic cfg_write_reg(input logic idx, input logic [47:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == arprr_pkg::CfgOwnIpv4) our_ipv4 = value[31:0];
    else our_mac = value;
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (frame_beats.size() != 0 || in_valid || reply_beats.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  // frame byte sender
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      wait_cnt <= 0;
    end else begin
      if (in_valid && in_ready) begin
        arp_absorb_byte(in_byte, in_last, !cur_beat.fixed);
        if (cur_beat.fixed)
          reply_beats.push_back(reply_beat_t'{8'h00, 1'b1, cur_beat.fixed_verdict});
      end
      if (!in_valid || in_ready) begin
        if (frame_beats.size() != 0 && wait_cnt >= frame_beats[0].gap) begin
          cur_beat <= frame_beats[0];
          in_byte  <= frame_beats[0].data;
          in_last  <= frame_beats[0].last;
          in_valid <= 1'b1;
          wait_cnt <= 0;
          void'(frame_beats.pop_front());
        end else begin
          in_valid <= 1'b0;
          if (frame_beats.size() != 0) wait_cnt <= wait_cnt + 1;
        end
      end
    end
  end

  // reply receiver and checker
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && out_ready) begin
      if (reply_beats.size() == 0) begin
        if (errors < 10)
          $display("unexpected beat: byte %h last %b verdict %0d", out_byte, out_last, verdict);
        errors = errors + 1;
      end else begin
        want = reply_beats.pop_front();
        if (out_byte !== want.data || out_last !== want.last || verdict !== want.verdict) begin
          if (errors < 10)
            $display({"mismatch: expected byte %h last %b verdict %0d, ",
                      "got byte %h last %b verdict %0d"},
                     want.data, want.last, want.verdict, out_byte, out_last, verdict);
          errors = errors + 1;
        end
      end
      stall_draw = $urandom_range(0, 12);
      if (stall_draw == 0) begin
        out_ready  <= !hold_off;
        stall_left <= 0;
      end else begin
        out_ready  <= 1'b0;
        stall_left <= stall_draw - 1;
      end
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= !hold_off;
    end
  end

  // long receiver hold-off so the block backs up
  initial begin
    wait (hold_req);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int              len;
    int              c;
    logic [15:0]     ht;
    logic [15:0]     pt;
    logic [15:0]     op;
    logic [7:0]      hl;
    logic [7:0]      pl;
    logic [31:0]     tip;
    logic [31:0]     ip;
    logic [47:0]     mac;
    directed_frame_t df;

    our_ipv4 = '0;
    our_mac = '0;
    rx_pos = '0;
    seen_hw_type = '0;
    seen_proto = '0;
    seen_hlen = '0;
    seen_plen = '0;
    seen_op = '0;
    seen_peer_mac = '0;
    seen_peer_ipv4 = '0;
    seen_target_ipv4 = '0;

    // reply with the reset configuration
    directed_frames[0] = '{42, 16'h0001, 16'h0800, 8'h06, 8'h04, 16'h0001, 1, 8'h00, 0,
                           arprr_pkg::VerdictReply};
    directed_frames[1] = '{1, 16'h0001, 16'h0800, 8'h06, 8'h04, 16'h0001, 1, 8'hFF, 1,
                           arprr_pkg::VerdictShort};
    directed_frames[2] = '{22, 16'h0002, 16'h0800, 8'h06, 8'h04, 16'h0001, 1, 8'h00, 1,
                           arprr_pkg::VerdictFormat};
    // long frame, byte position saturates
    directed_frames[3] = '{65, 16'h0001, 16'h0800, 8'h06, 8'h04, 16'h0001, 0, 8'h00, 1,
                           arprr_pkg::VerdictNotOurs};

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < 4; i++) begin
      if (i == 1) begin
        wait_idle();
        cfg_write_reg(arprr_pkg::CfgOwnIpv4, {16'hFFFF, 32'hC0A8_0001});
        cfg_write_reg(arprr_pkg::CfgOwnMac, 48'h0200_5E10_2030);
        hold_req = 1'b1;
      end
      df = directed_frames[i];
      tip = df.ours ? our_ipv4 : ~our_ipv4;
      queue_frame(df.len, df.htype, df.ptype, df.hlen, df.plen, df.op, tip, {6{df.fill}},
                  {4{df.fill}}, df.fill, 0, df.fixed, df.fixed_verdict);
    end

    wait_idle();
    ip = $urandom;
    mac = {16'($urandom), 32'($urandom)};
    cfg_write_reg(arprr_pkg::CfgOwnIpv4, {16'($urandom), ip});
    cfg_write_reg(arprr_pkg::CfgOwnMac, mac);
    while (queued < 160) begin
      c = $urandom_range(0, 99);
      if (c < 15) len = 42;
      else if (c < 60) len = $urandom_range(43, 64);
      else if (c < 80) len = $urandom_range(65, 72);
      else len = $urandom_range(1, 41);
      ht = arprr_pkg::HwTypeEth;
      pt = arprr_pkg::ProtoIpv4;
      hl = arprr_pkg::HwAddrLen;
      pl = arprr_pkg::ProtoAddrLen;
      c = $urandom_range(0, 19);
      if (c == 0) ht = 16'($urandom);
      else if (c == 1) pt = 16'($urandom);
      else if (c == 2) hl = 8'($urandom);
      else if (c == 3) pl = 8'($urandom);
      c = $urandom_range(0, 9);
      op = (c == 0) ? 16'($urandom) : (c == 1) ? arprr_pkg::OpReply : arprr_pkg::OpRequest;
      tip = ($urandom_range(0, 3) == 0) ? 32'($urandom) : our_ipv4;
      queue_frame(len, ht, pt, hl, pl, op, tip, {16'($urandom), 32'($urandom)}, $urandom,
                  8'h00, 1, 0, arprr_pkg::VerdictReply);
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (errors == 0 && reply_beats.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
